[rtl/prf_pkg.sv]
// Shared constants, types and the filter code list for the PNG scanline filter.
// Used by prf_line_store, prf_predictor and png_row_filter_top.
package prf_pkg;

  localparam int MAX_ROW_BYTES = 4096;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int COL_W         = 13;
  localparam int BPP_W         = 4;
  localparam int HIST_DEPTH    = 8;
  localparam int HIST_IDX_W    = $clog2(HIST_DEPTH);

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic CFG_BPP       = 1'b0;
  localparam logic CFG_ROW_BYTES = 1'b1;

  typedef logic [7:0] byte_t;

  // One pixel byte on its way from the line store read to the predictor.
  typedef struct packed {
    byte_t      raw;
    logic [2:0] filt;
    logic       top;
    logic       has_left;
    logic       row_start;
  } item_t;

endpackage

[rtl/prf_line_store.sv]
// Line store holding the raw bytes of the previous scanline.
// Synchronous memory, one write and one registered read per cycle; uses prf_pkg.
module prf_line_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [prf_pkg::ADDR_W-1:0] wr_addr,
  input  prf_pkg::byte_t             wr_data,
  input  logic                       re,
  input  logic [prf_pkg::ADDR_W-1:0] rd_addr,
  output prf_pkg::byte_t             rd_data
);
  import prf_pkg::*;

  byte_t mem [MAX_ROW_BYTES];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[rtl/prf_predictor.sv]
// Neighbor history and predictor: forms a, b, c, picks the prediction and subtracts.
// Uses prf_pkg; fed by the line store read data in png_row_filter_top.
module prf_predictor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  prf_pkg::item_t            item,
  input  prf_pkg::byte_t            up_raw,
  input  logic [prf_pkg::BPP_W-1:0] bpp,
  output prf_pkg::byte_t            filtered
);
  import prf_pkg::*;

  byte_t                 left_hist  [HIST_DEPTH];
  byte_t                 upleft_hist[HIST_DEPTH];
  logic [HIST_IDX_W-1:0] sel;
  logic [BPP_W-1:0]      bpp_m1;
  byte_t                 a, b, c, pred;
  logic [8:0]            avg_sum;
  logic [9:0]            pa, pb, pc;
  logic signed [10:0]    d_bc, d_ac, d_abc;

  assign bpp_m1 = bpp - BPP_W'(1);
  assign sel    = bpp_m1[HIST_IDX_W-1:0];
  assign b      = item.top ? 8'd0 : up_raw;
  assign a      = item.has_left ? left_hist[sel] : 8'd0;
  assign c      = item.has_left ? upleft_hist[sel] : 8'd0;

  // Paeth distances in the form that avoids the wide intermediate p.
  assign d_bc  = $signed({3'b000, b}) - $signed({3'b000, c});
  assign d_ac  = $signed({3'b000, a}) - $signed({3'b000, c});
  assign d_abc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
  assign pa    = d_bc[10]  ? 10'(-d_bc)  : d_bc[9:0];
  assign pb    = d_ac[10]  ? 10'(-d_ac)  : d_ac[9:0];
  assign pc    = d_abc[10] ? 10'(-d_abc) : d_abc[9:0];

  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (item.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign filtered = item.raw - pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else if (adv) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        left_hist[i]   <= left_hist[i-1];
        upleft_hist[i] <= upleft_hist[i-1];
      end
      left_hist[0]   <= item.raw;
      upleft_hist[0] <= b;
    end
  end

endmodule

[rtl/png_row_filter_top.sv]
// PNG scanline filter (none, sub, up, average, Paeth); top level.
// A result passes from the input through the second stage, where the line store read
// is in flight, and then the output register, from which it is offered on the output.
// Throughput: one byte per cycle; a row's first byte needs an extra output transfer
// because the filter type byte goes out ahead of it. The output port sets the pace.
// Reset clears the control state and loads bytes_per_pixel = 1 and row_bytes = 1;
// the line store is not cleared and needs no pass after reset.
module png_row_filter_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] raw_byte
  input  logic [3:0]  s_tuser,   // [2:0] filter_kind, [3] image_start
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tuser,   // [0] is_type_byte
  output logic        m_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import prf_pkg::*;

  // Configuration registers.
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [COL_W-1:0] row_bytes;
  logic [BPP_W-1:0] bpp_sat;
  logic [COL_W-1:0] rb_sat;

  // Row tracking state, updated as each input transfer is accepted.
  logic [ADDR_W-1:0] col, col_eff, col_next;
  logic              on_top_row, top_eff, top_next;
  logic [2:0]        row_filter, kind_ok, filt_now;
  logic [COL_W-1:0]  col_inc;
  logic              row_start, has_left;
  logic              s_acc;

  // Second stage: the line store read is in flight for this item.
  logic  s1_valid, s1_adv;
  item_t s1_item;
  byte_t up_raw, filtered;

  // Output register; it can hold a type byte in front of its pixel byte.
  logic       ov, two;
  byte_t      ob_pix;
  logic [2:0] ob_type;
  logic       m_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(1);
      row_bytes       <= COL_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BPP:       bytes_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_ROW_BYTES: row_bytes       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into their legal ranges.
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_sat = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(HIST_DEPTH)) begin
      bpp_sat = BPP_W'(HIST_DEPTH);
    end else begin
      bpp_sat = bytes_per_pixel;
    end
    if (row_bytes == '0) begin
      rb_sat = COL_W'(1);
    end else if (row_bytes > COL_W'(MAX_ROW_BYTES)) begin
      rb_sat = COL_W'(MAX_ROW_BYTES);
    end else begin
      rb_sat = row_bytes;
    end
  end

  assign s_acc = s_tvalid && s_tready;

  // An image start abandons the current row and starts again at the top.
  assign col_eff   = s_tuser[3] ? '0 : col;
  assign top_eff   = s_tuser[3] ? 1'b1 : on_top_row;
  assign row_start = (col_eff == '0);
  assign kind_ok   = (s_tuser[2:0] <= FILT_PAETH) ? s_tuser[2:0] : FILT_NONE;
  assign filt_now  = row_start ? kind_ok : row_filter;
  assign has_left  = ({1'b0, col_eff} >= (ADDR_W+1)'(bpp_sat));
  assign col_inc   = COL_W'(col_eff) + COL_W'(1);

  // The column never reaches MAX_ROW_BYTES, so it fits the address. A row length
  // that shrinks mid-row closes the row at the next byte.
  always_comb begin
    if (col_inc >= rb_sat) begin
      col_next = '0;
      top_next = 1'b0;
    end else begin
      col_next = col_inc[ADDR_W-1:0];
      top_next = top_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      on_top_row <= 1'b1;
      row_filter <= FILT_NONE;
    end else if (s_acc) begin
      col        <= col_next;
      on_top_row <= top_next;
      row_filter <= filt_now;
    end
  end

  // The item reads its up neighbor and overwrites it with its own raw byte in the
  // same cycle; the store returns the old contents, so no forwarding is needed.
  prf_line_store u_store (
    .clk     (clk),
    .we      (s_acc),
    .wr_addr (col_eff),
    .wr_data (s_tdata),
    .re      (s_acc),
    .rd_addr (col_eff),
    .rd_data (up_raw)
  );

  // The second stage moves on when the output register is empty or sends its
  // final transfer in this cycle.
  assign s1_adv   = s1_valid && (!ov || (m_tready && !two));
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_item.raw       <= s_tdata;
      s1_item.filt      <= filt_now;
      s1_item.top       <= top_eff;
      s1_item.has_left  <= has_left;
      s1_item.row_start <= row_start;
    end
  end

  prf_predictor u_pred (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .item     (s1_item),
    .up_raw   (up_raw),
    .bpp      (bpp_sat),
    .filtered (filtered)
  );

  assign m_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      two <= 1'b0;
    end else if (s1_adv) begin
      ov  <= 1'b1;
      two <= s1_item.row_start;
    end else if (m_acc) begin
      if (two) begin
        two <= 1'b0;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ob_pix  <= filtered;
      ob_type <= s1_item.filt;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = two ? {5'b00000, ob_type} : ob_pix;
  assign m_tuser  = two;
  assign m_tlast  = !two;

endmodule
